// ===== rtl/stq_pkg.sv =====
// stq_pkg: shared constants, codes and control types of the sorted timer queue.
// No dependencies; used by every other file of the block.
package stq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_BITS_DEF  = 8;

    localparam int OP_W   = 2;
    localparam int TID_W  = 8;
    localparam int EXP_W  = 32;
    localparam int ST_W   = 2;
    localparam int CNTO_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_PRESENT   = 2'd3;

    typedef struct packed {
        logic capture;
        logic apply;
    } t_cmd;

endpackage

// ===== rtl/stq_if.sv =====
// stq_in_if / stq_out_if: valid-ready channels for operations and results.
// Depends on stq_pkg for field widths.
interface stq_in_if;
    logic                       valid;
    logic                       ready;
    logic [stq_pkg::OP_W-1:0]   operation;
    logic [stq_pkg::TID_W-1:0]  timer_id;
    logic [stq_pkg::EXP_W-1:0]  expire_time;

    modport source (output valid, operation, timer_id, expire_time, input ready);
    modport sink   (input valid, operation, timer_id, expire_time, output ready);
endinterface

interface stq_out_if;
    logic                        valid;
    logic                        ready;
    logic [stq_pkg::ST_W-1:0]    status;
    logic                        head_valid;
    logic [stq_pkg::TID_W-1:0]   head_id;
    logic [stq_pkg::EXP_W-1:0]   head_expire;
    logic [stq_pkg::CNTO_W-1:0]  entry_count;

    modport source (output valid, status, head_valid, head_id, head_expire, entry_count,
                    input ready);
    modport sink   (input valid, status, head_valid, head_id, head_expire, entry_count,
                    output ready);
endinterface

// ===== rtl/stq_ctrl.sv =====
// stq_ctrl: sequencer of the timer queue (capture, lookup, apply) and output valid.
// Depends on stq_pkg (t_cmd).
module stq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output stq_pkg::t_cmd   o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_APPLY} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   commit, accept;

    assign commit     = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || commit;
    assign accept     = i_in_valid && o_in_ready;

    assign o_cmd.capture = accept;
    assign o_cmd.apply   = commit;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (accept) n_state = S_LOOK;
                else if (commit) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ===== rtl/stq_datapath.sv =====
// stq_datapath: row of compare-and-shift cells holding the sorted timers,
// lookup masks and the result register. Depends on stq_pkg.
module stq_datapath #(
    parameter int CAPACITY = stq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = stq_pkg::ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stq_pkg::t_cmd                i_cmd,
    input  logic [stq_pkg::OP_W-1:0]     i_operation,
    input  logic [stq_pkg::TID_W-1:0]    i_timer_id,
    input  logic [stq_pkg::EXP_W-1:0]    i_expire_time,
    output logic [stq_pkg::ST_W-1:0]     o_status,
    output logic                         o_head_valid,
    output logic [stq_pkg::TID_W-1:0]    o_head_id,
    output logic [stq_pkg::EXP_W-1:0]    o_head_expire,
    output logic [stq_pkg::CNTO_W-1:0]   o_entry_count
);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int IDI_W  = (ID_BITS < stq_pkg::TID_W) ? ID_BITS : stq_pkg::TID_W;
    localparam int CO_W   = (CNT_W < stq_pkg::CNTO_W) ? CNT_W : stq_pkg::CNTO_W;
    localparam int EXP_W  = stq_pkg::EXP_W;

    logic [stq_pkg::OP_W-1:0] r_op;
    logic [ID_BITS-1:0]       r_id;
    logic [EXP_W-1:0]         r_t;

    logic [ID_BITS-1:0]       r_cid  [CAPACITY];
    logic [EXP_W-1:0]         r_cexp [CAPACITY];
    logic [CNT_W-1:0]         r_count;

    logic [CAPACITY-1:0]      match, lt, r_match, r_lt;
    logic [IDX_W-1:0]         pos, r_pos;

    logic [CAPACITY-1:0]      gp, lt_r;
    logic [ID_BITS-1:0]       rm_id  [CAPACITY];
    logic [EXP_W-1:0]         rm_exp [CAPACITY];
    logic [ID_BITS-1:0]       n_cid  [CAPACITY];
    logic [EXP_W-1:0]         n_cexp [CAPACITY];
    logic [CNT_W-1:0]         n_count;
    logic                     found, full, do_rm, do_ins;
    logic [stq_pkg::ST_W-1:0] status;

    // lookup: per-cell id match and expiry compare, match position encode
    always_comb begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CNT_W'(i) < r_count) && (r_cid[i] == r_id);
            lt[i]    = (CNT_W'(i) < r_count) && (r_cexp[i] < r_t);
            if (match[i]) pos = pos | IDX_W'(i);
        end
    end

    // apply: remove at r_pos, then insert ahead of equal expiries
    always_comb begin
        found  = |r_match;
        full   = (r_count == CNT_W'(CAPACITY));
        do_rm  = found && ((r_op == stq_pkg::OP_ADJUST) || (r_op == stq_pkg::OP_DELETE));
        do_ins = ((r_op == stq_pkg::OP_INSERT) && !found && !full) ||
                 ((r_op == stq_pkg::OP_ADJUST) && found);
        case (r_op)
            stq_pkg::OP_INSERT: status = found ? stq_pkg::ST_PRESENT :
                                         (full ? stq_pkg::ST_FULL : stq_pkg::ST_OK);
            stq_pkg::OP_ADJUST,
            stq_pkg::OP_DELETE: status = found ? stq_pkg::ST_OK : stq_pkg::ST_NOT_FOUND;
            default:            status = stq_pkg::ST_OK;
        endcase
        n_count = r_count - CNT_W'(do_rm) + CNT_W'(do_ins);
        for (int i = 0; i < CAPACITY; i++) begin
            gp[i] = do_rm && (IDX_W'(i) >= r_pos);
            if (gp[i] && (i + 1 < CAPACITY)) begin
                rm_id[i]  = r_cid[(i + 1) % CAPACITY];
                rm_exp[i] = r_cexp[(i + 1) % CAPACITY];
                lt_r[i]   = r_lt[(i + 1) % CAPACITY];
            end else begin
                rm_id[i]  = r_cid[i];
                rm_exp[i] = r_cexp[i];
                lt_r[i]   = gp[i] ? 1'b0 : r_lt[i];
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (!do_ins || lt_r[i]) begin
                n_cid[i]  = rm_id[i];
                n_cexp[i] = rm_exp[i];
            end else if (i == 0 || lt_r[(i + CAPACITY - 1) % CAPACITY]) begin
                n_cid[i]  = r_id;
                n_cexp[i] = r_t;
            end else begin
                n_cid[i]  = rm_id[(i + CAPACITY - 1) % CAPACITY];
                n_cexp[i] = rm_exp[(i + CAPACITY - 1) % CAPACITY];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= match;
        r_lt    <= lt;
        r_pos   <= pos;
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_id <= ID_BITS'(i_timer_id[IDI_W-1:0]);
            r_t  <= i_expire_time;
        end
        if (i_cmd.apply) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cid[i]  <= n_cid[i];
                r_cexp[i] <= n_cexp[i];
            end
            o_status      <= status;
            o_head_valid  <= (n_count != '0);
            o_head_id     <= (n_count != '0) ? stq_pkg::TID_W'(n_cid[0]) : '0;
            o_head_expire <= (n_count != '0) ? n_cexp[0] : '0;
            o_entry_count <= stq_pkg::CNTO_W'(n_count[CO_W-1:0]);
        end
    end
endmodule

// ===== rtl/sorted_timer_queue.sv =====
// sorted_timer_queue: top level joining the sequencer and the cell datapath.
// Depends on stq_pkg, stq_in_if / stq_out_if, stq_ctrl and stq_datapath.
//
// Usage:
//   i_in carries one operation per item: insert, adjust expiry or delete of a
//   timer id. o_out returns one result per item: status, the earliest entry
//   (head_valid, head_id, head_expire) and the entry count after the change.
//   Entries sit in a row of compare-and-shift cells kept in ascending expiry
//   order; equal expiries place the newest entry first.
//   The accepted item passes a lookup state comparing every cell, then an
//   apply state shifting them, which registers the result.
//   Items pass the lookup/apply sequence one at a time; the next item is
//   taken in the same cycle the previous result is stored.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any pending
//   result; cell contents are not cleared.
//   If the receiver stalls, the result holds in the output register; one more
//   item may be accepted and looked up, then i_in.ready stays low until the
//   held result is taken.
module sorted_timer_queue #(
    parameter int CAPACITY = stq_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = stq_pkg::ID_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    stq_in_if.sink          i_in,
    stq_out_if.source       o_out
);
    stq_pkg::t_cmd cmd;

    stq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    stq_datapath #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_in.operation),
        .i_timer_id    (i_in.timer_id),
        .i_expire_time (i_in.expire_time),
        .o_status      (o_out.status),
        .o_head_valid  (o_out.head_valid),
        .o_head_id     (o_out.head_id),
        .o_head_expire (o_out.head_expire),
        .o_entry_count (o_out.entry_count)
    );

    a_apply_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.apply |=> o_out.valid)
        else $error("apply did not produce a result");

    a_lookup_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> !cmd.apply && !i_in.ready)
        else $error("apply issued without lookup cycle");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (CAPACITY < 128)) |-> (o_out.head_valid == (o_out.entry_count != 0)))
        else $error("head_valid disagrees with entry count");
endmodule

// ===== bench/testbench.sv =====
// testbench: random and directed check of sorted_timer_queue against a sorted-list predictor.
// Depends on stq_pkg, stq_in_if / stq_out_if and the sorted_timer_queue RTL.
`timescale 1ns / 1ps
module testbench;
    localparam int CAP = stq_pkg::CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [stq_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [stq_pkg::OP_W-1:0]  operation;
        logic [stq_pkg::TID_W-1:0] timer_id;
        logic [stq_pkg::EXP_W-1:0] expire_time;
    } t_op;

    typedef struct packed {
        logic [stq_pkg::ST_W-1:0]   status;
        logic                       head_valid;
        logic [stq_pkg::TID_W-1:0]  head_id;
        logic [stq_pkg::EXP_W-1:0]  head_expire;
        logic [stq_pkg::CNTO_W-1:0] entry_count;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    stq_in_if  in_ch ();
    stq_out_if out_ch ();

    sorted_timer_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_op  pending_ops[$];
    t_res expected_results[$];
    logic [stq_pkg::TID_W-1:0] list_ids[$];
    logic [stq_pkg::EXP_W-1:0] list_exp[$];
    int   error_count;
    int   idle_cycles;
    bit   quiet_mode;
    bit   hold_sender;
    bit   started;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int find_timer(input logic [stq_pkg::TID_W-1:0] id);
        for (int i = 0; i < list_ids.size(); i++)
            if (list_ids[i] == id) return i;
        return -1;
    endfunction

    function automatic void place_timer(input logic [stq_pkg::TID_W-1:0] id,
                                        input logic [stq_pkg::EXP_W-1:0] t);
        int pos;
        pos = 0;
        while (pos < list_exp.size() && list_exp[pos] < t) pos++;
        list_ids.insert(pos, id);
        list_exp.insert(pos, t);
    endfunction

    function automatic t_res apply_timer_op(input t_op op);
        t_res r;
        int idx;
        r = '0;
        r.status = stq_pkg::ST_OK;
        idx = find_timer(op.timer_id);
        if (op.operation == stq_pkg::OP_INSERT) begin
            if (idx >= 0) r.status = stq_pkg::ST_PRESENT;
            else if (list_ids.size() >= CAP) r.status = stq_pkg::ST_FULL;
            else place_timer(op.timer_id, op.expire_time);
        end else if (op.operation == stq_pkg::OP_ADJUST ||
                     op.operation == stq_pkg::OP_DELETE) begin
            if (idx < 0) begin
                r.status = stq_pkg::ST_NOT_FOUND;
            end else begin
                list_ids.delete(idx);
                list_exp.delete(idx);
                if (op.operation == stq_pkg::OP_ADJUST)
                    place_timer(op.timer_id, op.expire_time);
            end
        end
        if (list_ids.size() > 0) begin
            r.head_valid = 1'b1;
            r.head_id = list_ids[0];
            r.head_expire = list_exp[0];
        end
        r.entry_count = stq_pkg::CNTO_W'(list_ids.size());
        return r;
    endfunction

    function automatic logic [stq_pkg::EXP_W-1:0] rand_expiry();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [stq_pkg::OP_W-1:0] o,
                            input logic [stq_pkg::TID_W-1:0] id,
                            input logic [stq_pkg::EXP_W-1:0] t);
        pending_ops.push_back({o, id, t});
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) expected_results.push_back(apply_timer_op(
                {in_ch.operation, in_ch.timer_id, in_ch.expire_time}));
            if (pending_ops.size() > 0 && !hold_sender &&
                (quiet_mode || $urandom_range(0, 99) >= 16)) begin
                {in_ch.operation, in_ch.timer_id, in_ch.expire_time} <= pending_ops.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    t_res w;
                    w = expected_results.pop_front();
                    if (out_ch.status !== w.status)
                        report_mismatch("status", 64'(out_ch.status), 64'(w.status));
                    if (out_ch.head_valid !== w.head_valid)
                        report_mismatch("head_valid", 64'(out_ch.head_valid),
                                        64'(w.head_valid));
                    if (out_ch.head_id !== w.head_id)
                        report_mismatch("head_id", 64'(out_ch.head_id), 64'(w.head_id));
                    if (out_ch.head_expire !== w.head_expire)
                        report_mismatch("head_expire", 64'(out_ch.head_expire),
                                        64'(w.head_expire));
                    if (out_ch.entry_count !== w.entry_count)
                        report_mismatch("entry_count", 64'(out_ch.entry_count),
                                        64'(w.entry_count));
                end
            end
            out_ch.ready <= quiet_mode || $urandom_range(0, 99) >= 16;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !started)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [stq_pkg::TID_W-1:0] id;
        error_count = 0;
        quiet_mode = 1'b0;
        hold_sender = 1'b0;
        started = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.timer_id = '0;
        in_ch.expire_time = '0;
        out_ch.ready = 1'b0;

        // directed: empty ops, equal expiries, duplicates, extremes, unused code
        queue_op(stq_pkg::OP_DELETE, 8'd5, '0);
        queue_op(stq_pkg::OP_ADJUST, 8'd5, 32'd9);
        queue_op(stq_pkg::OP_INSERT, 8'd0, '1);
        queue_op(stq_pkg::OP_INSERT, 8'd255, '0);
        queue_op(stq_pkg::OP_INSERT, 8'd7, '0);
        queue_op(stq_pkg::OP_INSERT, 8'd7, 32'd3);
        queue_op(OP_SPARE, 8'd9, 32'd1);
        queue_op(stq_pkg::OP_ADJUST, 8'd255, '1);
        queue_op(stq_pkg::OP_ADJUST, 8'd0, '0);
        queue_op(stq_pkg::OP_ADJUST, 8'd7, 32'd0);
        queue_op(stq_pkg::OP_INSERT, 8'd170, 32'h5555_5555);
        queue_op(stq_pkg::OP_DELETE, 8'd0, '1);
        queue_op(stq_pkg::OP_DELETE, 8'd85, '0);
        queue_op(stq_pkg::OP_DELETE, 8'd7, '0);
        queue_op(stq_pkg::OP_DELETE, 8'd170, '0);
        queue_op(stq_pkg::OP_DELETE, 8'd255, '0);
        // fill to capacity, then one past, then drain partly
        for (int i = 0; i < CAP; i++) queue_op(stq_pkg::OP_INSERT, 8'(i * 3), rand_expiry());
        queue_op(stq_pkg::OP_INSERT, 8'd254, 32'd1);
        queue_op(stq_pkg::OP_INSERT, 8'd3, 32'd1);
        for (int i = 0; i < CAP; i += 2) queue_op(stq_pkg::OP_DELETE, 8'(i * 3), '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        started <= 1'b1;

        // pause until the queue is drained
        wait (pending_ops.size() == 0);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !in_ch.valid);
        hold_sender = 1'b0;

        for (int n = 0; n < 1400; n++) begin
            int r;
            if (n == 500) quiet_mode = 1'b1;
            if (n == 700) quiet_mode = 1'b0;
            r = $urandom_range(0, 99);
            // mostly ids from a narrow pool so adjust and delete hit
            id = (r < 85) ? 8'($urandom_range(0, 79)) : 8'($urandom);
            if (r < 45) queue_op(stq_pkg::OP_INSERT, id, rand_expiry());
            else if (r < 70) queue_op(stq_pkg::OP_ADJUST, id, rand_expiry());
            else if (r < 97) queue_op(stq_pkg::OP_DELETE, id, $urandom);
            else queue_op(OP_SPARE, id, $urandom);
            if (n == 1000) begin
                for (int k = 0; k < 80; k++)
                    queue_op(stq_pkg::OP_INSERT, 8'($urandom_range(80, 255)),
                             $urandom_range(0, 3));
            end
            while (pending_ops.size() > 8) @(posedge i_clk);
        end

        wait (pending_ops.size() == 0 && !in_ch.valid && expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
